[hw/rtl/ax25_pkg.sv]
// ----------------------------------------------------------------------------
// ax25_pkg: shared types and constants
// Sizes, register indexes, status codes, sequencer states, address layout.
// ----------------------------------------------------------------------------
package ax25_pkg;

  localparam int FrameBytes     = 256;
  localparam int TextBytes      = 512;
  localparam int MaxDigipeaters = 8;

  localparam int FrameAw = $clog2(FrameBytes);
  localparam int TextAw  = $clog2(TextBytes);
  localparam int FcW     = FrameAw + 1;
  localparam int TcW     = TextAw + 1;
  localparam int PosW    = FcW + 1;

  localparam logic [1:0] RegControl  = 2'd0;
  localparam logic [1:0] RegProtocol = 2'd1;
  localparam logic [1:0] RegSsid     = 2'd2;
  localparam logic [1:0] RegRepeated = 2'd3;

  localparam logic [1:0] StLoading  = 2'd0;
  localparam logic [1:0] StDone     = 2'd1;
  localparam logic [1:0] StRejected = 2'd2;
  localparam logic [1:0] StOverflow = 2'd3;

  localparam logic [7:0] ChBrace = 8'h7D;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam logic [PosW-1:0] AddrLen   = PosW'(7);
  localparam logic [PosW-1:0] SrcBase   = PosW'(7);
  localparam logic [PosW-1:0] DigiBase  = PosW'(14);
  localparam logic [PosW-1:0] MinPos    = PosW'(13);
  localparam logic [PosW-1:0] FirstChk  = PosW'(20);
  localparam logic [6:0]      SsidTen   = 7'd9;

  typedef enum logic [4:0] {
    S_IDLE, S_FIND_RD, S_FIND_CMP, S_CHECK_RD, S_CHECK, S_ADDR_RD, S_ADDR_CH,
    S_END_RD, S_END, S_SSID1, S_SSIDN, S_STAR, S_SEP, S_COLON, S_PAY_RD,
    S_PAY, S_RESULT, S_FINISH
  } seq_state_e;

  // Write request from the sequencer to the text store.
  typedef struct packed {
    logic       en;
    logic [7:0] ch;
  } text_put_t;

endpackage

[hw/rtl/ax25_text_mem.sv]
// ----------------------------------------------------------------------------
// ax25_text_mem: text store with append and readout
// Append port with overflow flag; read port with registered data.
// ----------------------------------------------------------------------------
module ax25_text_mem import ax25_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  text_put_t        put_i,
  input  logic             rd_en_i,
  output logic [7:0]       rd_data_o,
  output logic [TcW-1:0]   count_o,
  output logic [TcW-1:0]   rptr_o,
  output logic             spill_o
);

  logic [7:0]     mem [TextBytes];
  logic [TcW-1:0] count_q, count_d, rptr_q, rptr_d;
  logic           spill_q, spill_d;
  logic           wr_en;

  assign wr_en = put_i.en && (count_q < TcW'(TextBytes));

  always_comb begin
    count_d = count_q;
    rptr_d  = rptr_q;
    spill_d = spill_q;
    if (clear_i) begin
      count_d = '0;
      rptr_d  = '0;
      spill_d = 1'b0;
    end else if (put_i.en) begin
      if (wr_en) count_d = count_q + 1'b1;
      else       spill_d = 1'b1;
    end
    if (rd_en_i) rptr_d = rptr_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rptr_q  <= '0;
      spill_q <= 1'b0;
    end else begin
      count_q <= count_d;
      rptr_q  <= rptr_d;
      spill_q <= spill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[count_q[TextAw-1:0]] <= put_i.ch;
    if (rd_en_i) rd_data_o <= mem[rptr_q[TextAw-1:0]];
  end

  assign count_o = count_q;
  assign rptr_o  = rptr_q;
  assign spill_o = spill_q;

  ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= TcW'(TextBytes)) else $error("text count beyond store");
  ap_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> rptr_q < count_q) else $error("read past text end");
  ap_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (put_i.en && !clear_i && count_q == TcW'(TextBytes)) |=> spill_q)
    else $error("overflow not flagged");

endmodule

[hw/rtl/ax25_ui_frame_to_aprs_text.sv]
// ----------------------------------------------------------------------------
// ax25_ui_frame_to_aprs_text: AX.25 UI frame to APRS-IS text converter
// Loads frame bytes, converts on the final byte, then reads text out.
// ----------------------------------------------------------------------------
// A load or read is accepted in S_IDLE; S_RESULT then flags the result valid.
// A final load walks the frame through one shared compare/index unit and the
// single frame memory port: it searches for the control/protocol byte pair,
// then copies the address fields and payload bytes into the text store.
// Throughput: one transaction at a time; in_ready_o is low while busy and while
// a result waits.
// Reset: async active low; clears counters, status, flags; config to defaults.
module ax25_ui_frame_to_aprs_text import ax25_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  frame_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  text_char_o,
  output logic        text_last_o,
  output logic [1:0]  status_o,
  output logic [9:0]  text_length_o
);

  // Configuration registers.
  logic [7:0] ctrl_q, proto_q, rep_q;
  logic [6:0] ssid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= 8'd3;
      proto_q <= 8'd240;
      ssid_q  <= 7'd15;
      rep_q   <= 8'd128;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegControl:  ctrl_q  <= cfg_data_i;
        RegProtocol: proto_q <= cfg_data_i;
        RegSsid:     ssid_q  <= cfg_data_i[6:0];
        RegRepeated: rep_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame memory: single port, registered read.
  logic [7:0]         fmem [FrameBytes];
  logic [7:0]         frd_q;
  logic [FrameAw-1:0] faddr;
  logic               fwe;

  // Sequencer registers.
  seq_state_e       state_q, state_d;
  logic [FcW-1:0]   fcount_q, fcount_d, size_q, size_d;
  logic [PosW-1:0]  p_q, p_d, pos_q, pos_d, base_q, base_d, chk_q, chk_d;
  logic [PosW-1:0]  chk_nx;
  logic [7:0]       prev_q, prev_d, end_q, end_d, dig_q, dig_d;
  logic [2:0]       k_q, k_d;
  logic [3:0]       n_q, n_d;
  logic             mark_q, mark_d, dst_q, dst_d;
  logic [1:0]       stat_q, stat_d;
  logic             rd_q, rd_d, last_q, last_d;
  logic             ovalid_q, ovalid_d;
  logic [7:0]       ochar_q, ochar_d;

  // Text store interface.
  text_put_t      put;
  logic           tclear, trd;
  logic [7:0]     tdata;
  logic [TcW-1:0] tcount, trptr;
  logic           tspill;

  // Shared unit: one index into the frame with a bounds check.
  logic [PosW-1:0] idx;
  logic            idx_ok;
  logic [7:0]      fb;   // registered frame byte, zero beyond store
  logic            fb_ok_q;
  logic [6:0]      ssid_v;

  assign idx_ok = idx < PosW'(FrameBytes);
  assign fb     = fb_ok_q ? frd_q : 8'd0;
  assign faddr  = fwe ? fcount_q[FrameAw-1:0] : idx[FrameAw-1:0];

  // Digipeater threshold for the next separator decision.
  assign chk_nx = mark_q ? chk_q + AddrLen : chk_q;

  always_ff @(posedge clk_i) begin
    if (fwe) fmem[fcount_q[FrameAw-1:0]] <= frame_byte_i;
    frd_q   <= fmem[faddr];
    fb_ok_q <= idx_ok;
  end

  always_comb begin
    state_d  = state_q;
    fcount_d = fcount_q;
    size_d   = size_q;
    p_d      = p_q;
    pos_d    = pos_q;
    base_d   = base_q;
    chk_d    = chk_q;
    prev_d   = prev_q;
    end_d    = end_q;
    dig_d    = dig_q;
    k_d      = k_q;
    n_d      = n_q;
    mark_d   = mark_q;
    dst_d    = dst_q;
    stat_d   = stat_q;
    rd_d     = rd_q;
    last_d   = last_q;
    ovalid_d = ovalid_q;
    ochar_d  = ochar_q;
    idx      = p_q;
    fwe      = 1'b0;
    tclear   = 1'b0;
    trd      = 1'b0;
    put      = '{en: 1'b0, ch: 8'd0};
    ssid_v   = end_q[6:0] & ssid_q;
    in_ready_o = 1'b0;

    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = !ovalid_q;
        if (in_valid_i && !ovalid_q) begin
          rd_d   = 1'b0;
          last_d = 1'b0;
          if (kind_i) begin
            // Read: fetch next text character when one remains.
            if (trptr < tcount) begin
              trd    = 1'b1;
              rd_d   = 1'b1;
              last_d = (trptr + 1'b1) == tcount;
            end
            state_d = S_RESULT;
          end else begin
            if (fcount_q < FcW'(FrameBytes)) begin
              fwe      = 1'b1;
              fcount_d = fcount_q + 1'b1;
            end
            if (final_byte_i) begin
              size_d  = (fcount_q < FcW'(FrameBytes)) ? fcount_q + 1'b1 : fcount_q;
              p_d     = '0;
              pos_d   = '0;
              state_d = S_FIND_RD;
            end else begin
              stat_d  = StLoading;
              state_d = S_RESULT;
            end
          end
        end
      end
      // Search: read byte p, compare against previous as pair (p-1, p).
      S_FIND_RD: begin
        if (p_q >= PosW'(size_q)) begin
          fcount_d = '0;
          state_d  = S_CHECK_RD;
        end else begin
          state_d = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        prev_d = fb;
        if (p_q > PosW'(1) && prev_q == ctrl_q && fb == proto_q) begin
          pos_d    = p_q - 1'b1;
          fcount_d = '0;
          state_d  = S_CHECK_RD;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = S_FIND_RD;
        end
      end
      S_CHECK_RD: begin
        tclear = 1'b1;
        idx    = pos_q + PosW'(2);
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!(pos_q > MinPos && (pos_q + PosW'(2)) < PosW'(size_q)) || fb == ChBrace) begin
          stat_d  = StRejected;
          state_d = S_RESULT;
        end else begin
          base_d  = SrcBase;
          mark_d  = 1'b0;
          dst_d   = 1'b0;
          n_d     = '0;
          chk_d   = FirstChk;
          k_d     = '0;
          state_d = S_ADDR_RD;
        end
      end
      S_ADDR_RD: begin
        idx     = base_q + PosW'(k_q);
        state_d = S_ADDR_CH;
      end
      S_ADDR_CH: begin
        put = '{en: fb != ChSpace, ch: fb};
        if (k_q == 3'd5) begin
          state_d = S_END_RD;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_ADDR_RD;
        end
      end
      S_END_RD: begin
        idx     = base_q + PosW'(6);
        state_d = S_END;
      end
      S_END: begin
        end_d = fb;
        ssid_v = fb[6:0] & ssid_q;
        if (ssid_v != '0) begin
          put     = '{en: 1'b1, ch: ChDash};
          state_d = S_SSID1;
        end else begin
          state_d = S_STAR;
        end
      end
      S_SSID1: begin
        if (ssid_v > SsidTen) begin
          put    = '{en: 1'b1, ch: ChOne};
          dig_d  = {1'b0, ssid_v - 7'd10};
        end else begin
          dig_d  = {1'b0, ssid_v};
        end
        state_d = S_SSIDN;
      end
      S_SSIDN: begin
        put     = '{en: 1'b1, ch: dig_q + ChZero};
        state_d = S_STAR;
      end
      S_STAR: begin
        if (mark_q && (end_q & rep_q) != 8'd0)
          put = '{en: 1'b1, ch: ChStar};
        state_d = S_SEP;
      end
      S_SEP: begin
        k_d = '0;
        if (!dst_q && !mark_q) begin
          put     = '{en: 1'b1, ch: ChGt};
          dst_d   = 1'b1;
          base_d  = '0;
          state_d = S_ADDR_RD;
        end else if (pos_q > chk_nx && n_q < 4'(MaxDigipeaters)) begin
          put     = '{en: 1'b1, ch: ChComma};
          base_d  = mark_q ? base_q + AddrLen : DigiBase;
          chk_d   = chk_nx;
          mark_d  = 1'b1;
          n_d     = n_q + 1'b1;
          state_d = S_ADDR_RD;
        end else begin
          state_d = S_COLON;
        end
      end
      S_COLON: begin
        put     = '{en: 1'b1, ch: ChColon};
        p_d     = (mark_q ? base_q + AddrLen : DigiBase) + PosW'(2);
        state_d = S_PAY_RD;
      end
      S_PAY_RD: begin
        if (p_q >= PosW'(size_q)) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_PAY;
        end
      end
      S_PAY: begin
        put     = '{en: 1'b1, ch: fb};
        p_d     = p_q + 1'b1;
        state_d = S_PAY_RD;
      end
      S_FINISH: begin
        stat_d  = tspill ? StOverflow : StDone;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        ovalid_d = 1'b1;
        ochar_d  = rd_q ? tdata : 8'd0;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fcount_q <= '0;
      stat_q   <= StLoading;
      ovalid_q <= 1'b0;
      rd_q     <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      fcount_q <= fcount_d;
      stat_q   <= stat_d;
      ovalid_q <= ovalid_d;
      rd_q     <= rd_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q  <= size_d;
    p_q     <= p_d;
    pos_q   <= pos_d;
    base_q  <= base_d;
    chk_q   <= chk_d;
    prev_q  <= prev_d;
    end_q   <= end_d;
    dig_q   <= dig_d;
    k_q     <= k_d;
    n_q     <= n_d;
    mark_q  <= mark_d;
    dst_q   <= dst_d;
    ochar_q <= ochar_d;
  end

  ax25_text_mem u_text (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (tclear),
    .put_i     (put),
    .rd_en_i   (trd),
    .rd_data_o (tdata),
    .count_o   (tcount),
    .rptr_o    (trptr),
    .spill_o   (tspill)
  );

  assign out_valid_o   = ovalid_q;
  assign text_char_o   = ochar_q;
  assign text_last_o   = last_q && rd_q;
  assign status_o      = stat_q;
  assign text_length_o = 10'(tcount);

  ap_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ready_o) else $error("ready while busy");
  ap_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o) else $error("stale result");
  ap_frame_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcount_q <= FcW'(FrameBytes)) else $error("frame count overrun");

endmodule
